>>> design/swlru_pkg.sv
`timescale 1ns / 1ps
package swlru_pkg;
   localparam int unsigned ENTRIES_DEFAULT = 64;
   localparam int unsigned MAX_RESULTS = 64;
   localparam logic [23:0] BUDGET_RESET = 24'd1049000;
   localparam logic [19:0] LIMIT_RESET = 20'd102400;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   localparam logic [2:0] KIND_MISS = 3'd0;
   localparam logic [2:0] KIND_HIT = 3'd1;
   localparam logic [2:0] KIND_INSERTED = 3'd2;
   localparam logic [2:0] KIND_REJECTED = 3'd3;
   localparam logic [2:0] KIND_EVICTED = 3'd4;

   localparam logic [0:0] REG_BUDGET = 1'd0;
   localparam logic [0:0] REG_LIMIT = 1'd1;

   typedef struct packed {
      logic        opcode;
      logic [63:0] key;
      logic [19:0] obj_size;
      logic [31:0] handle;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [5:0]  slot;
      logic [63:0] entry_key_out;
      logic [31:0] entry_handle_out;
      logic [19:0] entry_size_out;
      logic [23:0] bytes_used;
      logic        last;
   } rsp_type;
endpackage

>>> design/swlru_if.sv
`timescale 1ns / 1ps
interface swlru_req_if;
   logic                 valid;
   logic                 ready;
   swlru_pkg::req_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface swlru_rsp_if;
   logic                 valid;
   logic                 ready;
   swlru_pkg::rsp_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> design/swlru_ram.sv
`timescale 1ns / 1ps
module swlru_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

>>> design/size_weighted_lru_directory_unit.sv
`timescale 1ns / 1ps
// directory of a byte-budgeted lru object cache. requests arrive on req (opcode 0 lookup and
// promote, 1 insert), results leave on rsp, last marking the final result of a request.
// evicted results leave one at a time, each eviction waiting until the previous result is
// taken. a result held by the receiver stalls the eviction and insert-write steps and keeps
// req.ready low. entries live in one ram (key, handle, size) and the recency order in a
// second ram (position 0 = most recently used); both have registered reads. a request is
// handled by a sequencer that walks the recency ram one position at a time. a lookup reads
// positions from the front and compares each entry's key; on a hit it issues the result, then
// shifts the order down to promote the hit to position 0; a miss is reported once all live
// entries have been searched. an insert sums sizes from the lru end until the object fits,
// evicts those entries one by one, scans the remaining entries for the lowest free slot and
// shifts the order to make room at the front before writing the entry. the recency ram port
// paces all of these walks. slot memory contents are undefined after reset; only live entries
// are read. csr registers: 0 cache_budget (24 bits), 1 object_limit (20 bits), byte addresses
// 0 and 4; writes are expected only while no request is in flight.
module size_weighted_lru_directory_unit #(
   parameter int unsigned ENTRIES = swlru_pkg::ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   swlru_req_if.sink   req,
   swlru_rsp_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int unsigned AW = $clog2(ENTRIES);
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam int unsigned EW = 64 + 32 + 20;
   localparam logic [CW-1:0] FULL = CW'(ENTRIES);
   localparam logic [CW-1:0] MAXEV = CW'(swlru_pkg::MAX_RESULTS - 1);

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LREAD  = 4'd1;  // lookup: read order[p]
   localparam logic [3:0] S_LENT   = 4'd2;  // lookup: read entry of slot
   localparam logic [3:0] S_LCMP   = 4'd3;  // lookup: compare key
   localparam logic [3:0] S_SHIFT  = 4'd4;  // read order[p-1]
   localparam logic [3:0] S_SHWR   = 4'd5;  // write order[p]
   localparam logic [3:0] S_SUMRD  = 4'd6;  // insert: read order[cnt-1-k]
   localparam logic [3:0] S_SUMENT = 4'd7;
   localparam logic [3:0] S_SUMADD = 4'd8;
   localparam logic [3:0] S_EVRD   = 4'd9;  // evict: read order[cnt-1]
   localparam logic [3:0] S_EVENT  = 4'd10;
   localparam logic [3:0] S_EVOUT  = 4'd11;
   localparam logic [3:0] S_SCAN   = 4'd12; // mark taken slots
   localparam logic [3:0] S_SCANW  = 4'd13;
   localparam logic [3:0] S_OUT    = 4'd14; // not entered by the sequencer
   localparam logic [3:0] S_INSWR  = 4'd15;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [23:0]   used_ff, used_in;
   logic [23:0]   budget_ff;
   logic [19:0]   limit_ff;
   logic [CW-1:0] pos_ff, pos_in;       // position pointer
   logic [CW-1:0] k_ff, k_in;
   logic [24:0]   freed_ff, freed_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [ENTRIES-1:0] taken_ff, taken_in;
   logic          after_ff, after_in;   // shift followed by insert write
   swlru_pkg::req_type cur_ff, cur_in;
   logic          rv_ff, rv_in;
   swlru_pkg::rsp_type rsp_ff, rsp_in;

   // memories
   logic          ewe, owe;
   logic [AW-1:0] ewa, era, owa, ora;
   logic [EW-1:0] ewd, erd;
   logic [AW-1:0] owd, ord_q;

   swlru_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_entry (
      .clock(clock), .wr_en(ewe), .wr_addr(ewa), .wr_data(ewd),
      .rd_addr(era), .rd_data(erd));
   swlru_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_order (
      .clock(clock), .wr_en(owe), .wr_addr(owa), .wr_data(owd),
      .rd_addr(ora), .rd_data(ord_q));

   logic [63:0] e_key;
   logic [31:0] e_hdl;
   logic [19:0] e_size;
   assign {e_key, e_hdl, e_size} = erd;

   logic csr_wr;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr[2])
         swlru_pkg::REG_BUDGET: csr_prdata = {8'd0, budget_ff};
         default:               csr_prdata = {12'd0, limit_ff};
      endcase
   end

   assign req.ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.payload = rsp_ff;

   logic [25:0] need;
   assign need = 26'(used_ff) - 26'(freed_ff) + 26'(cur_ff.obj_size);
   logic fits;
   assign fits = need <= 26'(budget_ff);

   logic [AW-1:0] free_slot;
   always_comb begin
      free_slot = AW'(ENTRIES - 1);
      for (int i = ENTRIES - 2; i >= 0; i--)
         if (!taken_ff[i]) free_slot = AW'(i);
   end

   always_comb begin
      state_in = state_ff; count_in = count_ff; used_in = used_ff;
      pos_in = pos_ff; k_in = k_ff; freed_in = freed_ff; slot_in = slot_ff;
      taken_in = taken_ff; after_in = after_ff; cur_in = cur_ff;
      rv_in = rv_ff; rsp_in = rsp_ff;
      ewe = 1'b0; ewa = slot_ff; ewd = {cur_ff.key, cur_ff.handle, cur_ff.obj_size};
      era = ord_q; owe = 1'b0; owa = pos_ff[AW-1:0]; owd = ord_q;
      ora = pos_ff[AW-1:0];
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid && !rv_ff) begin
               cur_in = req.payload;
               pos_in = '0; k_in = '0; freed_in = '0; taken_in = '0;
               if (req.payload.opcode == swlru_pkg::OP_LOOKUP) state_in = S_LREAD;
               else if (req.payload.obj_size > limit_ff) begin
                  rsp_in = '{kind: swlru_pkg::KIND_REJECTED, slot: '0, entry_key_out: '0,
                     entry_handle_out: '0, entry_size_out: '0, bytes_used: used_ff, last: 1'b1};
                  rv_in = 1'b1;
               end else state_in = S_SUMRD;
            end
         end
         S_LREAD: begin
            if (pos_ff == count_ff) begin
               rsp_in = '{kind: swlru_pkg::KIND_MISS, slot: '0, entry_key_out: '0,
                  entry_handle_out: '0, entry_size_out: '0, bytes_used: used_ff, last: 1'b1};
               rv_in = 1'b1; state_in = S_IDLE;
            end else state_in = S_LENT;
         end
         S_LENT: begin
            slot_in = ord_q; state_in = S_LCMP;
         end
         S_LCMP: begin
            if (e_key == cur_ff.key) begin
               rsp_in = '{kind: swlru_pkg::KIND_HIT, slot: 6'(slot_ff), entry_key_out: e_key,
                  entry_handle_out: e_hdl, entry_size_out: e_size, bytes_used: used_ff,
                  last: 1'b1};
               rv_in = 1'b1; after_in = 1'b0; state_in = S_SHIFT;
            end else begin
               pos_in = pos_ff + 1'b1; state_in = S_LREAD;
            end
         end
         S_SHIFT: begin
            // order[p] = order[p-1] down to p = 1, then order[0] = slot
            if (pos_ff == '0) begin
               owe = 1'b1; owa = '0; owd = slot_ff;
               if (after_ff) state_in = S_INSWR;
               else state_in = S_IDLE;
            end else begin
               ora = AW'(pos_ff - 1'b1); state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            owe = 1'b1; owa = pos_ff[AW-1:0]; owd = ord_q;
            pos_in = pos_ff - 1'b1; state_in = S_SHIFT;
         end
         S_SUMRD: begin
            if (k_ff == count_ff || fits) begin
               if (!fits) begin
                  rsp_in = '{kind: swlru_pkg::KIND_REJECTED, slot: '0, entry_key_out: '0,
                     entry_handle_out: '0, entry_size_out: '0, bytes_used: used_ff,
                     last: 1'b1};
                  rv_in = 1'b1; state_in = S_IDLE;
               end else if (k_ff > MAXEV) begin
                  rsp_in = '{kind: swlru_pkg::KIND_REJECTED, slot: '0, entry_key_out: '0,
                     entry_handle_out: '0, entry_size_out: '0, bytes_used: used_ff,
                     last: 1'b1};
                  rv_in = 1'b1; state_in = S_IDLE;
               end else begin
                  if (k_ff == '0 && count_ff >= FULL) k_in = CW'(1);
                  state_in = S_EVRD;
               end
            end else begin
               ora = AW'(count_ff - 1'b1 - k_ff); state_in = S_SUMENT;
            end
         end
         S_SUMENT: state_in = S_SUMADD;
         S_SUMADD: begin
            freed_in = freed_ff + 25'(e_size); k_in = k_ff + 1'b1; state_in = S_SUMRD;
         end
         S_EVRD: begin
            if (k_ff == '0) begin
               pos_in = '0; state_in = S_SCAN;
            end else if (!rv_ff || rsp.ready) begin
               ora = AW'(count_ff - 1'b1); state_in = S_EVENT;
            end
         end
         S_EVENT: begin
            slot_in = ord_q; state_in = S_EVOUT;
         end
         S_EVOUT: begin
            used_in = used_ff - 24'(e_size);
            count_in = count_ff - 1'b1;
            rsp_in = '{kind: swlru_pkg::KIND_EVICTED, slot: 6'(slot_ff), entry_key_out: e_key,
               entry_handle_out: e_hdl, entry_size_out: e_size,
               bytes_used: used_ff - 24'(e_size), last: 1'b0};
            rv_in = 1'b1; k_in = k_ff - 1'b1; state_in = S_EVRD;
         end
         S_SCAN: begin
            if (pos_ff == count_ff) begin
               slot_in = free_slot; after_in = 1'b1; state_in = S_SHIFT;
            end else state_in = S_SCANW;
         end
         S_SCANW: begin
            taken_in[ord_q] = 1'b1; pos_in = pos_ff + 1'b1; state_in = S_SCAN;
         end
         S_INSWR: begin
            if (!rv_ff || rsp.ready) begin
               ewe = 1'b1;
               count_in = count_ff + 1'b1;
               used_in = used_ff + 24'(cur_ff.obj_size);
               rsp_in = '{kind: swlru_pkg::KIND_INSERTED, slot: 6'(slot_ff),
                  entry_key_out: cur_ff.key, entry_handle_out: cur_ff.handle,
                  entry_size_out: cur_ff.obj_size,
                  bytes_used: used_ff + 24'(cur_ff.obj_size), last: 1'b1};
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; used_ff <= '0; rv_ff <= 1'b0;
         budget_ff <= swlru_pkg::BUDGET_RESET; limit_ff <= swlru_pkg::LIMIT_RESET;
      end else begin
         state_ff <= state_in; count_ff <= count_in; used_ff <= used_in; rv_ff <= rv_in;
         if (csr_wr) begin
            case (csr_paddr[2])
               swlru_pkg::REG_BUDGET: budget_ff <= csr_pwdata[23:0];
               default:               limit_ff <= csr_pwdata[19:0];
            endcase
         end
      end
      pos_ff <= pos_in; k_ff <= k_in; freed_ff <= freed_in; slot_ff <= slot_in;
      taken_ff <= taken_in; after_ff <= after_in; cur_ff <= cur_in; rsp_ff <= rsp_in;
   end

   // entry count never exceeds table size
   a_count: assert property (@(posedge clock) disable iff (reset) count_ff <= FULL)
      else $error("entry count overflow");
   // a held result is not overwritten
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp.ready |=> rv_ff && rsp_ff == $past(rsp_ff))
      else $error("result overwritten while stalled");
   // requests only taken when idle
   a_acc: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |-> state_ff == S_IDLE)
      else $error("request accepted while busy");
endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   localparam int unsigned DEPTH = 64;
   localparam int unsigned STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   swlru_req_if req_ch ();
   swlru_rsp_if rsp_ch ();

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   size_weighted_lru_directory_unit #(.ENTRIES(DEPTH)) uut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // directory shadow: keys, handles, sizes per slot and the recency list
   logic [63:0] dir_key [DEPTH];
   logic [31:0] dir_handle [DEPTH];
   logic [19:0] dir_size [DEPTH];
   int unsigned mru_list [DEPTH];
   int unsigned live_count;
   logic [23:0] bytes_cached;
   logic [23:0] budget_reg;
   logic [19:0] limit_reg;

   swlru_pkg::rsp_type expected_rsps [$];
   int          error_count = 0;

   // pacing knobs, changed per phase
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_off_cycles = 0;
   int unsigned quiet_cycles = 0;
   bit          timed_out = 1'b0;

   function automatic swlru_pkg::rsp_type make_rsp(logic [2:0] kind, int unsigned slot,
                                                   logic [63:0] k, logic [31:0] h,
                                                   logic [19:0] sz, logic lst);
      swlru_pkg::rsp_type r;
      r.kind = kind;
      r.slot = slot[5:0];
      r.entry_key_out = k;
      r.entry_handle_out = h;
      r.entry_size_out = sz;
      r.bytes_used = bytes_cached;
      r.last = lst;
      return r;
   endfunction

   // apply one request to the shadow directory and queue its results
   task automatic predict_directory(input swlru_pkg::req_type rq);
      int unsigned pos, slot, evict_n, freed;
      bit          found;
      bit          taken [DEPTH];
      if (rq.opcode == swlru_pkg::OP_LOOKUP) begin
         found = 1'b0;
         for (pos = 0; pos < live_count && !found; pos++) begin
            slot = mru_list[pos];
            if (dir_key[slot] == rq.key) begin
               found = 1'b1;
               for (int p = pos; p > 0; p--) mru_list[p] = mru_list[p-1];
               mru_list[0] = slot;
               expected_rsps.push_back(make_rsp(swlru_pkg::KIND_HIT, slot, dir_key[slot],
                                                dir_handle[slot], dir_size[slot], 1'b1));
            end
         end
         if (!found)
            expected_rsps.push_back(make_rsp(swlru_pkg::KIND_MISS, 0, '0, '0, '0, 1'b1));
         return;
      end
      // insert: count evictions from the lru end until the object fits
      freed = 0;
      evict_n = 0;
      if (rq.obj_size <= limit_reg) begin
         while (evict_n < live_count &&
                bytes_cached - freed + rq.obj_size > budget_reg) begin
            freed += dir_size[mru_list[live_count - 1 - evict_n]];
            evict_n++;
         end
      end
      if (rq.obj_size > limit_reg || bytes_cached - freed + rq.obj_size > budget_reg) begin
         expected_rsps.push_back(make_rsp(swlru_pkg::KIND_REJECTED, 0, '0, '0, '0, 1'b1));
         return;
      end
      if (evict_n == 0 && live_count >= DEPTH) evict_n = 1;
      if (evict_n + 1 > swlru_pkg::MAX_RESULTS) begin
         expected_rsps.push_back(make_rsp(swlru_pkg::KIND_REJECTED, 0, '0, '0, '0, 1'b1));
         return;
      end
      while (evict_n > 0) begin
         slot = mru_list[live_count - 1];
         live_count--;
         bytes_cached -= dir_size[slot];
         expected_rsps.push_back(make_rsp(swlru_pkg::KIND_EVICTED, slot, dir_key[slot],
                                          dir_handle[slot], dir_size[slot], 1'b0));
         evict_n--;
      end
      // lowest free slot
      foreach (taken[i]) taken[i] = 1'b0;
      for (pos = 0; pos < live_count; pos++) taken[mru_list[pos]] = 1'b1;
      for (slot = 0; slot < DEPTH - 1 && taken[slot]; slot++) ;
      dir_key[slot] = rq.key;
      dir_handle[slot] = rq.handle;
      dir_size[slot] = rq.obj_size;
      for (int p = live_count; p > 0; p--) mru_list[p] = mru_list[p-1];
      mru_list[0] = slot;
      live_count++;
      bytes_cached += rq.obj_size;
      expected_rsps.push_back(make_rsp(swlru_pkg::KIND_INSERTED, slot, rq.key, rq.handle,
                                       rq.obj_size, 1'b1));
   endtask

   // sender: one request, waits for the handshake
   task automatic send_request(input logic op, input logic [63:0] k, input logic [19:0] sz,
                               input logic [31:0] h);
      swlru_pkg::req_type rq;
      rq.opcode = op;
      rq.key = k;
      rq.obj_size = sz;
      rq.handle = h;
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      @(negedge clock);
      req_ch.payload <= rq;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      predict_directory(rq);
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // register write, setup then access
   task automatic write_csr(input logic [0:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      csr_pwrite <= 1'b1;
      csr_psel <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == swlru_pkg::REG_BUDGET) budget_reg = value[23:0];
      else limit_reg = value[19:0];
   endtask

   // wait for all expected results, then let a walk's worth of cycles pass
   task automatic drain_results();
      while (expected_rsps.size() != 0 && !timed_out) @(negedge clock);
      repeat (600) @(negedge clock);
   endtask

   // receiver readiness, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_off_cycles != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      swlru_pkg::rsp_type got, want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (expected_rsps.size() == 0) begin
               $error("unexpected result kind %0d slot %0d", got.kind, got.slot);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.kind !== want.kind) begin
                  $error("kind expected %0d got %0d", want.kind, got.kind); error_count++;
               end
               if (got.slot !== want.slot) begin
                  $error("slot expected %0d got %0d", want.slot, got.slot); error_count++;
               end
               if (got.entry_key_out !== want.entry_key_out) begin
                  $error("entry_key_out expected %h got %h", want.entry_key_out,
                         got.entry_key_out); error_count++;
               end
               if (got.entry_handle_out !== want.entry_handle_out) begin
                  $error("entry_handle_out expected %h got %h", want.entry_handle_out,
                         got.entry_handle_out); error_count++;
               end
               if (got.entry_size_out !== want.entry_size_out) begin
                  $error("entry_size_out expected %0d got %0d", want.entry_size_out,
                         got.entry_size_out); error_count++;
               end
               if (got.bytes_used !== want.bytes_used) begin
                  $error("bytes_used expected %0d got %0d", want.bytes_used, got.bytes_used);
                  error_count++;
               end
               if (got.last !== want.last) begin
                  $error("last expected %0d got %0d", want.last, got.last); error_count++;
               end
            end
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // recently inserted keys, so lookups hit
   logic [63:0] key_pool [$];

   function automatic logic [63:0] pick_key();
      if (key_pool.size() != 0 && $urandom_range(99) < 70)
         return key_pool[$urandom_range(key_pool.size() - 1)];
      return {$urandom, $urandom};
   endfunction

   task automatic insert_item(input logic [63:0] k, input logic [19:0] sz);
      key_pool.push_back(k);
      if (key_pool.size() > 40) void'(key_pool.pop_front());
      send_request(swlru_pkg::OP_INSERT, k, sz, $urandom);
   endtask

   // extremes of fields, misses, hits, duplicates, reject paths
   task automatic test_directed();
      send_request(swlru_pkg::OP_LOOKUP, 64'h0, 20'h0, 32'h0);        // miss on empty
      insert_item(64'hFFFF_FFFF_FFFF_FFFF, 20'd0);                    // zero-size entry
      insert_item(64'h0, 20'd102400);                                 // exactly the limit
      send_request(swlru_pkg::OP_INSERT, 64'h5, 20'd102401, 32'hFFFF_FFFF); // too big
      send_request(swlru_pkg::OP_INSERT, 64'h6, 20'hFFFFF, 32'h0);    // max size
      insert_item(64'h1234, 20'd7);
      insert_item(64'h1234, 20'd9);                                   // duplicate key
      send_request(swlru_pkg::OP_LOOKUP, 64'h1234, 20'hFFFFF, 32'hFFFF_FFFF);
      send_request(swlru_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 20'h0, 32'h0);
      send_request(swlru_pkg::OP_LOOKUP, 64'h0, 20'h0, 32'h0);
      send_request(swlru_pkg::OP_LOOKUP, 64'hDEAD, 20'h0, 32'h0);
      drain_results();
      // budget lowered below usage, then an insert forcing evictions
      write_csr(swlru_pkg::REG_BUDGET, 32'd50000);
      write_csr(swlru_pkg::REG_LIMIT, 32'hFFFFF);
      insert_item(64'hA, 20'd40000);
      send_request(swlru_pkg::OP_INSERT, 64'hB, 20'd60000, 32'h1);   // larger than budget
      drain_results();
      // zero budget: only zero-size objects fit
      write_csr(swlru_pkg::REG_BUDGET, 32'd0);
      write_csr(swlru_pkg::REG_LIMIT, 32'd0);
      insert_item(64'hC, 20'd0);
      send_request(swlru_pkg::OP_INSERT, 64'hD, 20'd1, 32'h2);
      drain_results();
      write_csr(swlru_pkg::REG_BUDGET, 32'hFFFFFF);
      write_csr(swlru_pkg::REG_LIMIT, 32'hFFFFF);
   endtask

   // small objects, table wraps and evicts on count; then one huge insert
   task automatic test_table_full();
      for (int i = 0; i < 70; i++)
         insert_item({$urandom, $urandom}, 20'($urandom_range(0, 20)));
      send_request(swlru_pkg::OP_INSERT, 64'h77, 20'hFFFFF, 32'h3);  // max size on a full table
      drain_results();
      write_csr(swlru_pkg::REG_BUDGET, 32'd1000);
      insert_item(64'h78, 20'd990);                           // would evict all, so rejected
      drain_results();
   endtask

   task automatic test_random(input int unsigned count, input logic [19:0] max_sz);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 50)
            insert_item(pick_key(), 20'($urandom_range(0, max_sz)));
         else send_request(swlru_pkg::OP_LOOKUP, pick_key(), 20'($urandom), $urandom);
      end
      drain_results();
   endtask

   // receiver stalls for a long time while requests keep coming
   task automatic test_backpressure();
      hold_off_cycles = 3000;
      for (int i = 0; i < 20; i++)
         insert_item({$urandom, $urandom}, 20'($urandom_range(0, 4000)));
      drain_results();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      live_count = 0;
      bytes_cached = '0;
      budget_reg = swlru_pkg::BUDGET_RESET;
      limit_reg = swlru_pkg::LIMIT_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 7;
      recv_idle_pct = 67;
      test_directed();
      test_table_full();
      write_csr(swlru_pkg::REG_BUDGET, 32'd20000);
      write_csr(swlru_pkg::REG_LIMIT, 32'd8000);
      test_random(60, 20'd9000);

      send_idle_pct = 67;
      recv_idle_pct = 7;
      write_csr(swlru_pkg::REG_BUDGET, 32'(swlru_pkg::BUDGET_RESET));
      write_csr(swlru_pkg::REG_LIMIT, 32'(swlru_pkg::LIMIT_RESET));
      test_random(60, 20'd110000);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(swlru_pkg::REG_BUDGET, 32'd12000);
      test_backpressure();
      test_random(60, 20'd3000);

      if (error_count == 0 && expected_rsps.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
